// File: rtl/sed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sed_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_literal;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_in_run;
  } out_word_t;

  // words made by one input, in output order
  typedef struct packed {
    logic [1:0]      count;
    out_word_t [1:0] words;
  } dec_result_t;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_OCT   = 2'd2;
  localparam logic [1:0] MODE_HEX   = 2'd3;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_QMARK     = 8'h3F;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_V         = 8'h76;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_VTAB      = 8'h0B;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_FORMFEED  = 8'h0C;
  localparam logic [7:0] CH_BELL      = 8'h07;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_F   = 8'h46;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd10;

  // {hit, byte} for the single-character escapes
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      CH_N:         r = {1'b1, CH_NEWLINE};
      CH_T:         r = {1'b1, CH_TAB};
      CH_V:         r = {1'b1, CH_VTAB};
      CH_B:         r = {1'b1, CH_BACKSPACE};
      CH_R:         r = {1'b1, CH_CR};
      CH_F:         r = {1'b1, CH_FORMFEED};
      CH_A:         r = {1'b1, CH_BELL};
      CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
      CH_QMARK:     r = {1'b1, CH_QMARK};
      CH_SQUOTE:    r = {1'b1, CH_SQUOTE};
      CH_DQUOTE:    r = {1'b1, CH_DQUOTE};
      default:      r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

  // {hit, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'h00;
    r = 5'h00;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      r = {1'b1, d[3:0]};
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      d = c - CH_LOWER_A + HEX_ALPHA_OFS;
      r = {1'b1, d[3:0]};
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d = c - CH_UPPER_A + HEX_ALPHA_OFS;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

  function automatic logic is_oct_digit(input logic [7:0] c);
    return c[7:3] == 5'b00110;
  endfunction

endpackage
`default_nettype wire

// File: rtl/sed_decode.sv
`timescale 1ns / 1ps
`default_nettype none
module sed_decode (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire sed_pkg::in_word_t  item,
  output sed_pkg::dec_result_t    res
);

  logic [1:0] mode;
  logic [7:0] value;
  logic [1:0] count;
  logic [1:0] mode_next;
  logic [7:0] value_next;
  logic [1:0] count_next;

  logic [7:0] c;
  logic       to_esc;
  logic       plain_out;
  logic [8:0] simple;
  logic [4:0] hexd;
  logic [7:0] oct_val;
  logic [7:0] hex_val;
  logic       a_valid;
  logic [7:0] a_byte;
  logic       b_valid;
  logic       f_valid;
  logic [7:0] f_byte;

  always_comb begin
    c         = item.in_byte;
    to_esc    = (c == sed_pkg::CH_BACKSLASH);
    plain_out = !to_esc && (c != sed_pkg::CH_DQUOTE);
    simple    = sed_pkg::simple_escape(c);
    hexd      = sed_pkg::hex_digit(c);
    oct_val   = {value[4:0], c[2:0]};
    hex_val   = {value[3:0], hexd[3:0]};

    mode_next  = mode;
    value_next = value;
    count_next = count;
    a_valid    = 1'b0;
    a_byte     = value;
    b_valid    = 1'b0;
    f_valid    = 1'b0;

    unique case (mode)
      sed_pkg::MODE_PLAIN: begin
        mode_next = to_esc ? sed_pkg::MODE_ESC : sed_pkg::MODE_PLAIN;
        b_valid   = plain_out;
      end
      sed_pkg::MODE_ESC: begin
        mode_next = sed_pkg::MODE_PLAIN;
        if (simple[8]) begin
          a_valid = 1'b1;
          a_byte  = simple[7:0];
        end else if (c == sed_pkg::CH_X) begin
          mode_next  = sed_pkg::MODE_HEX;
          value_next = 8'h00;
          count_next = 2'd0;
        end else if (sed_pkg::is_oct_digit(c)) begin
          mode_next  = sed_pkg::MODE_OCT;
          value_next = {5'b0, c[2:0]};
          count_next = 2'd1;
        end
      end
      sed_pkg::MODE_OCT: begin
        if (sed_pkg::is_oct_digit(c)) begin
          if (count[1]) begin
            a_valid    = 1'b1;
            a_byte     = oct_val;
            mode_next  = sed_pkg::MODE_PLAIN;
            value_next = 8'h00;
            count_next = 2'd0;
          end else begin
            value_next = oct_val;
            count_next = count + 2'd1;
          end
        end else begin
          a_valid    = 1'b1;
          value_next = 8'h00;
          count_next = 2'd0;
          mode_next  = to_esc ? sed_pkg::MODE_ESC : sed_pkg::MODE_PLAIN;
          b_valid    = plain_out;
        end
      end
      sed_pkg::MODE_HEX: begin
        if (hexd[4]) begin
          value_next = hex_val;
        end else begin
          a_valid    = 1'b1;
          value_next = 8'h00;
          count_next = 2'd0;
          mode_next  = to_esc ? sed_pkg::MODE_ESC : sed_pkg::MODE_PLAIN;
          b_valid    = plain_out;
        end
      end
    endcase

    // end of literal: flush a pending numeric escape, then back to reset
    f_byte = value_next;
    if (item.end_of_literal) begin
      f_valid    = (mode_next == sed_pkg::MODE_OCT) || (mode_next == sed_pkg::MODE_HEX);
      mode_next  = sed_pkg::MODE_PLAIN;
      value_next = 8'h00;
      count_next = 2'd0;
    end

    res.count = {1'b0, a_valid} + {1'b0, b_valid} + {1'b0, f_valid};
    res.words[0].out_byte    = a_valid ? a_byte : (b_valid ? c : f_byte);
    res.words[0].last_in_run = !(a_valid && (b_valid || f_valid));
    res.words[1].out_byte    = b_valid && a_valid ? c : f_byte;
    res.words[1].last_in_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= sed_pkg::MODE_PLAIN;
      value <= 8'h00;
      count <= 2'd0;
    end else if (advance) begin
      mode  <= mode_next;
      value <= value_next;
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/sed_outq.sv
`timescale 1ns / 1ps
`default_nettype none
module sed_outq (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire sed_pkg::dec_result_t  res,
  output logic                       ready,
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output sed_pkg::out_word_t         rsp_data
);

  sed_pkg::out_word_t [1:0] slots;
  logic [1:0]               fill;
  logic                     pop;

  assign rsp_valid = (fill != 2'd0);
  assign rsp_data  = slots[0];
  assign pop       = rsp_valid && !rsp_stall;
  // take a new input only once the queue empties this cycle
  assign ready     = (fill == 2'd0) || ((fill == 2'd1) && !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (push) begin
      fill <= res.count;
    end else if (pop) begin
      fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots <= res.words;
    end else if (pop) begin
      slots[0] <= slots[1];
    end
  end

endmodule
`default_nettype wire

// File: rtl/string_escape_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Decodes the body of a C string literal, one raw byte per accepted req word,
// into decoded bytes on the rsp channel (zero, one or two words per input,
// last_in_run marking the final one). Simple escapes, octal (up to three
// digits) and hex escapes are resolved, illegal escapes and bare double
// quotes are dropped, and a pending numeric escape is flushed on
// end_of_literal. One input byte per cycle is sustained while rsp_stall is
// low; an input that yields two words holds req_stall while the two-entry
// result queue drains. Results appear the cycle after an input is accepted.
module string_escape_decoder_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire sed_pkg::in_word_t   req_data,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output sed_pkg::out_word_t       rsp_data
);

  sed_pkg::dec_result_t res;
  logic                 ready;
  logic                 advance;

  assign req_stall = !ready;
  assign advance   = req_valid && ready;

  sed_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (req_data),
    .res     (res)
  );

  sed_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .res       (res),
    .ready     (ready),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule
`default_nettype wire

// File: rtl/sed_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sed_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_stall,
  input wire sed_pkg::in_word_t  req_data,
  input wire logic               rsp_valid,
  input wire logic               rsp_stall,
  input wire sed_pkg::out_word_t rsp_data
);

  // stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result word changed");

  // a word that is not last is followed by another
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && !rsp_data.last_in_run |=> rsp_valid)
    else $error("second result word missing");

  // input only stalls behind pending results
  assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("input stalled with no pending result");

  // no new input while the first of two words waits
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.last_in_run |-> req_stall)
    else $error("input taken while a word pair is pending");

endmodule

bind string_escape_decoder_unit sed_checker u_sed_checker (.*);
`default_nettype wire
